@@ design/hcc_pkg.sv @@
package hcc_pkg;

   // Default sizing of the block.
   localparam int HCC_MAX_POINTS  = 1024;
   localparam int HCC_COORD_WIDTH = 16;

   // Fraction bits of the curve parameter and of the basis weights.
   localparam int FRAC_W = 16;
   // The curve parameter u runs from 0 to 1.0 inclusive: unsigned Q1.16.
   localparam int Q_W = FRAC_W + 1;
   // The basis weights are signed and reach 3*u^2 at most before the subtraction.
   localparam int WGT_W = Q_W + 2;
   // Half of one LSB after a drop of FRAC_W bits.
   localparam int ROUND_HALF = 1 << (FRAC_W - 1);

   // Sample count after reset.
   localparam int RESET_COUNT = 64;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_START_POINT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_END_POINT     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_START_TANGENT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_END_TANGENT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_POINT_COUNT   = 3'd4;

   // 1.0 in the weight format.
   localparam logic signed [WGT_W-1:0] WGT_ONE = WGT_W'(1 << FRAC_W);

   // The four Hermite basis weights of one sample.
   typedef struct packed {
      logic signed [WGT_W-1:0] h0;
      logic signed [WGT_W-1:0] h1;
      logic signed [WGT_W-1:0] h2;
      logic signed [WGT_W-1:0] h3;
   } weights_type;

endpackage

@@ design/hermite_cubic_curve_point.sv @@
// Channel   Direction  Ports                                  Beat
// req       in         req_valid/req_ready, req_sample_index   one sample index
// rsp       out        rsp_valid/rsp_ready, rsp_pos_x/y/z,     one curve point
//                      rsp_saturated
// csr       in         csr_write_en, csr_index, csr_wdata      one register write
//
// One beat is accepted per cycle while the skid register is free; u = i/(N-1)
// is formed by the 17-stage restoring divider ahead of the basis and blend.
// Reset clears the valid bits, the point and tangent registers and sets N to 64.
// When a result waits and a second one arrives it goes to a skid register and
// the whole pipeline holds until rsp takes a beat; req_ready is low meanwhile.
module hermite_cubic_curve_point
   import hcc_pkg::*;
#(
   parameter int MAX_POINTS  = HCC_MAX_POINTS,
   parameter int COORD_WIDTH = HCC_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [$clog2(MAX_POINTS)-1:0] req_sample_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_pos_x,
   output logic signed [COORD_WIDTH-1:0] rsp_pos_y,
   output logic signed [COORD_WIDTH-1:0] rsp_pos_z,
   output logic                          rsp_saturated,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [3*COORD_WIDTH-1:0]      csr_wdata
);

   localparam int CW         = COORD_WIDTH;
   localparam int VEC_W      = 3 * CW;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
   localparam int NUM_W      = IDX_W + FRAC_W;
   localparam int RESET_LAST =
      ((RESET_COUNT > MAX_POINTS) ? MAX_POINTS : RESET_COUNT) - 1;

   logic [VEC_W-1:0]   start_point_ff, end_point_ff, start_tangent_ff, end_tangent_ff;
   logic [IDX_W-1:0]   last_ff, last_in;
   logic [COUNT_W-1:0] count_wr;
   logic               adv;
   logic [IDX_W-1:0]   idx_clamp;
   logic [NUM_W-1:0]   num_in, num_ff;
   logic               vld0_ff;
   logic               div_vld, bas_vld, bl_vld;
   logic [Q_W-1:0]     u;
   weights_type        wgt;
   logic signed [CW-1:0] bl_x, bl_y, bl_z;
   logic               bl_sat;
   logic               mv, take;
   logic               out_vld_ff, skid_vld_ff;
   logic [CW-1:0]      out_x_ff, out_y_ff, out_z_ff;
   logic [CW-1:0]      skid_x_ff, skid_y_ff, skid_z_ff;
   logic               out_sat_ff, skid_sat_ff;

   // The sample count is stored as N-1, clamped to the supported range.
   assign count_wr = csr_wdata[COUNT_W-1:0];

   always_comb begin
      if (count_wr < COUNT_W'(2)) begin
         last_in = IDX_W'(1);
      end else if (count_wr > COUNT_W'(MAX_POINTS)) begin
         last_in = IDX_W'(MAX_POINTS - 1);
      end else begin
         last_in = IDX_W'(count_wr - COUNT_W'(1));
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_point_ff   <= '0;
         end_point_ff     <= '0;
         start_tangent_ff <= '0;
         end_tangent_ff   <= '0;
         last_ff          <= IDX_W'(RESET_LAST);
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_START_POINT:   start_point_ff   <= csr_wdata;
            REG_END_POINT:     end_point_ff     <= csr_wdata;
            REG_START_TANGENT: start_tangent_ff <= csr_wdata;
            REG_END_TANGENT:   end_tangent_ff   <= csr_wdata;
            REG_POINT_COUNT:   last_ff          <= last_in;
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the skid register is free.
   assign adv       = !skid_vld_ff;
   assign req_ready = adv;

   // Input stage: clamp the index and form i*2^16 + (N-1)/2.
   assign idx_clamp = (req_sample_index > last_ff) ? last_ff : req_sample_index;
   assign num_in    = {idx_clamp, FRAC_W'(0)} + NUM_W'(last_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_in;
      end
   end

   hcc_divider #(
      .IDX_W (IDX_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (vld0_ff),
      .num     (num_ff),
      .den     (last_ff),
      .out_vld (div_vld),
      .quot    (u)
   );

   hcc_basis u_basis (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (div_vld),
      .u       (u),
      .out_vld (bas_vld),
      .wgt     (wgt)
   );

   hcc_blend #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_blend (
      .clock         (clock),
      .reset         (reset),
      .en            (adv),
      .in_vld        (bas_vld),
      .wgt           (wgt),
      .start_point   (start_point_ff),
      .end_point     (end_point_ff),
      .start_tangent (start_tangent_ff),
      .end_tangent   (end_tangent_ff),
      .out_vld       (bl_vld),
      .res_x         (bl_x),
      .res_y         (bl_y),
      .res_z         (bl_z),
      .res_sat       (bl_sat)
   );

   // A result leaves the pipeline this cycle, and a beat is taken at rsp.
   assign mv   = bl_vld && adv;
   assign take = out_vld_ff && rsp_ready;

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (take) begin
         if (skid_vld_ff) begin
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= mv;
         end
      end else if (mv) begin
         if (out_vld_ff) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_vld_ff) begin
         out_x_ff   <= skid_x_ff;
         out_y_ff   <= skid_y_ff;
         out_z_ff   <= skid_z_ff;
         out_sat_ff <= skid_sat_ff;
      end else if (mv && (take || !out_vld_ff)) begin
         out_x_ff   <= bl_x;
         out_y_ff   <= bl_y;
         out_z_ff   <= bl_z;
         out_sat_ff <= bl_sat;
      end
      if (mv && out_vld_ff && !take) begin
         skid_x_ff   <= bl_x;
         skid_y_ff   <= bl_y;
         skid_z_ff   <= bl_z;
         skid_sat_ff <= bl_sat;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_pos_x     = out_x_ff;
   assign rsp_pos_y     = out_y_ff;
   assign rsp_pos_z     = out_z_ff;
   assign rsp_saturated = out_sat_ff;

endmodule

@@ design/hcc_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, Q_W stages.
// The quotient is known to fit in Q_W bits because the numerator is below
// the divisor times 2^Q_W.
module hcc_divider
   import hcc_pkg::*;
#(
   parameter int IDX_W = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  logic [IDX_W+FRAC_W-1:0] num,
   input  logic [IDX_W-1:0]       den,
   output logic                   out_vld,
   output logic [Q_W-1:0]         quot
);

   localparam int NUMX_W = IDX_W + Q_W;

   logic [NUMX_W-1:0] numx;
   logic [IDX_W-1:0]  rem_src [Q_W];
   logic [Q_W-1:0]    low_src [Q_W];
   logic [Q_W-1:0]    vld_src;
   logic [IDX_W-1:0]  rem_in  [Q_W];
   logic [Q_W-1:0]    low_in  [Q_W];
   logic [IDX_W-1:0]  rem_ff  [Q_W];
   logic [Q_W-1:0]    low_ff  [Q_W];
   logic [Q_W-1:0]    vld_ff;

   // The top IDX_W bits start as the partial remainder; the rest shift in.
   assign numx = {1'b0, num};

   // Each stage reads the register of the stage before it.
   always_comb begin
      rem_src[0] = numx[NUMX_W-1:Q_W];
      low_src[0] = numx[Q_W-1:0];
      vld_src[0] = in_vld;
      for (int k = 1; k < Q_W; k++) begin
         rem_src[k] = rem_ff[k-1];
         low_src[k] = low_ff[k-1];
         vld_src[k] = vld_ff[k-1];
      end
   end

   // One trial subtraction per stage; the quotient bit enters at the bottom.
   always_comb begin
      logic [IDX_W:0] trial;
      logic           ge;
      for (int k = 0; k < Q_W; k++) begin
         trial = {rem_src[k], low_src[k][Q_W-1]};
         ge = (trial >= {1'b0, den});
         rem_in[k] = ge ? IDX_W'(trial - {1'b0, den}) : trial[IDX_W-1:0];
         low_in[k] = {low_src[k][Q_W-2:0], ge};
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_src;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < Q_W; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
         end
      end
   end

   assign out_vld = vld_ff[Q_W-1];
   assign quot    = low_ff[Q_W-1];

endmodule

@@ design/hcc_basis.sv @@
// Powers of u and the four Hermite basis weights, in four register stages.
module hcc_basis
   import hcc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_vld,
   input  logic [Q_W-1:0] u,
   output logic           out_vld,
   output weights_type    wgt
);

   localparam int SQ_W = 2 * Q_W;

   logic              vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic [SQ_W-1:0]   usq_in, usq_ff;
   logic [Q_W-1:0]    u1_ff, u2s_ff, u3s_ff;
   logic [SQ_W-1:0]   usq_rnd;
   logic [Q_W-1:0]    u2_in, u2_ff, u2d_ff;
   logic [SQ_W-1:0]   ucub_in, ucub_ff;
   logic [SQ_W-1:0]   ucub_rnd;
   logic [Q_W-1:0]    u3;
   logic signed [WGT_W-1:0] ux, u2x, u3x;
   weights_type       wgt_in, wgt_ff;

   // Stage 1: u squared, full width.
   assign usq_in = SQ_W'(u) * SQ_W'(u);

   // Stage 2: round the square back to Q1.16.
   assign usq_rnd = usq_ff + SQ_W'(ROUND_HALF);
   assign u2_in   = usq_rnd[FRAC_W +: Q_W];

   // Stage 3: u cubed from the rounded square.
   assign ucub_in = SQ_W'(u2_ff) * SQ_W'(u2s_ff);

   // Stage 4: round the cube and form the weights.
   assign ucub_rnd = ucub_ff + SQ_W'(ROUND_HALF);
   assign u3       = ucub_rnd[FRAC_W +: Q_W];
   assign ux       = WGT_W'(u3s_ff);
   assign u2x      = WGT_W'(u2d_ff);
   assign u3x      = WGT_W'(u3);

   always_comb begin
      wgt_in.h0 = u3x + u3x - u2x - u2x - u2x + WGT_ONE;
      wgt_in.h1 = u2x + u2x + u2x - u3x - u3x;
      wgt_in.h2 = u3x - u2x - u2x + ux;
      wgt_in.h3 = u3x - u2x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   // The u value rides along so that stages 3 and 4 can use it.
   always_ff @(posedge clock) begin
      if (en) begin
         usq_ff  <= usq_in;
         u1_ff   <= u;
         u2_ff   <= u2_in;
         u2s_ff  <= u1_ff;
         ucub_ff <= ucub_in;
         u2d_ff  <= u2_ff;
         u3s_ff  <= u2s_ff;
         wgt_ff  <= wgt_in;
      end
   end

   // The square is captured once more alongside the cube, so that stage 4
   // sees the square of its own item and not that of the one behind it.
   assign out_vld = vld4_ff;
   assign wgt     = wgt_ff;

endmodule

@@ design/hcc_blend.sv @@
// Weighted sum of the four control vectors for x, y and z, then rounding to
// Q8.8 and saturation. Two register stages; the final add and clip feed the
// output register of the top level.
module hcc_blend
   import hcc_pkg::*;
#(
   parameter int COORD_WIDTH = HCC_COORD_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  weights_type                wgt,
   input  logic [3*COORD_WIDTH-1:0]   start_point,
   input  logic [3*COORD_WIDTH-1:0]   end_point,
   input  logic [3*COORD_WIDTH-1:0]   start_tangent,
   input  logic [3*COORD_WIDTH-1:0]   end_tangent,
   output logic                       out_vld,
   output logic signed [COORD_WIDTH-1:0] res_x,
   output logic signed [COORD_WIDTH-1:0] res_y,
   output logic signed [COORD_WIDTH-1:0] res_z,
   output logic                       res_sat
);

   localparam int CW     = COORD_WIDTH;
   localparam int PROD_W = WGT_W + CW;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int RND_W  = SUM_W - FRAC_W;

   logic                     vld1_ff, vld2_ff;
   logic signed [PROD_W-1:0] prod_in [3][4];
   logic signed [PROD_W-1:0] prod_ff [3][4];
   logic signed [PAIR_W-1:0] pa_in [3], pb_in [3];
   logic signed [PAIR_W-1:0] pa_ff [3], pb_ff [3];
   logic [CW-1:0]            coord [3];
   logic [2:0]               sat;

   // Stage 1: twelve products, one per weight and coordinate.
   always_comb begin
      logic signed [CW-1:0] c0, c1, c2, c3;
      for (int k = 0; k < 3; k++) begin
         c0 = start_point[k*CW +: CW];
         c1 = end_point[k*CW +: CW];
         c2 = start_tangent[k*CW +: CW];
         c3 = end_tangent[k*CW +: CW];
         prod_in[k][0] = PROD_W'(wgt.h0) * PROD_W'(c0);
         prod_in[k][1] = PROD_W'(wgt.h1) * PROD_W'(c1);
         prod_in[k][2] = PROD_W'(wgt.h2) * PROD_W'(c2);
         prod_in[k][3] = PROD_W'(wgt.h3) * PROD_W'(c3);
      end
   end

   // Stage 2: pairwise sums.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pa_in[k] = PAIR_W'(prod_ff[k][0]) + PAIR_W'(prod_ff[k][1]);
         pb_in[k] = PAIR_W'(prod_ff[k][2]) + PAIR_W'(prod_ff[k][3]);
      end
   end

   // Final sum, round half up, drop the fraction and clip to the output range.
   always_comb begin
      logic signed [SUM_W-1:0] sum;
      logic [RND_W-1:0]        rnd;
      logic                    hi, lo;
      for (int k = 0; k < 3; k++) begin
         sum = SUM_W'(pa_ff[k]) + SUM_W'(pb_ff[k]) + SUM_W'(ROUND_HALF);
         rnd = sum[SUM_W-1:FRAC_W];
         hi  = !rnd[RND_W-1] && (|rnd[RND_W-2:CW-1]);
         lo  = rnd[RND_W-1] && !(&rnd[RND_W-2:CW-1]);
         if (hi) begin
            coord[k] = {1'b0, {(CW-1){1'b1}}};
         end else if (lo) begin
            coord[k] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            coord[k] = rnd[CW-1:0];
         end
         sat[k] = hi || lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
      end
   end

   assign out_vld = vld2_ff;
   assign res_x   = coord[0];
   assign res_y   = coord[1];
   assign res_z   = coord[2];
   assign res_sat = |sat;

endmodule

@@ sim/hermite_cubic_curve_point_test.sv @@
module hermite_cubic_curve_point_test
   import hcc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_W = $clog2(HCC_MAX_POINTS);
   localparam int VEC_W = 3 * HCC_COORD_WIDTH;
   localparam int CNT_W = 11;
   localparam longint UNIT_Q16 = longint'(1) << FRAC_W;
   localparam longint COORD_MAX = (longint'(1) << (HCC_COORD_WIDTH - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   // Indexes 5 to 7 decode to no register at all.
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_UNUSED = 3'd5;
   localparam int PHASES = 20;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int SETTLE_CYCLES = 40;

   // Expected curve points, computed from a private copy of the registers.
   class curve_scoreboard;
      typedef struct {
         logic [IDX_W-1:0]                  idx;
         logic signed [HCC_COORD_WIDTH-1:0] x;
         logic signed [HCC_COORD_WIDTH-1:0] y;
         logic signed [HCC_COORD_WIDTH-1:0] z;
         logic                              sat;
      } curve_point_type;

      logic [VEC_W-1:0] start_pt;
      logic [VEC_W-1:0] end_pt;
      logic [VEC_W-1:0] start_tan;
      logic [VEC_W-1:0] end_tan;
      logic [CNT_W-1:0] count_reg;
      curve_point_type  expected_q[$];
      int               mismatches;
      int               points_checked;
      int               saturated_seen;

      function void clear();
         start_pt       = '0;
         end_pt         = '0;
         start_tan      = '0;
         end_tan        = '0;
         count_reg      = CNT_W'(RESET_COUNT);
         mismatches     = 0;
         points_checked = 0;
         saturated_seen = 0;
         expected_q.delete();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [VEC_W-1:0] data);
         case (idx)
            REG_START_POINT:   start_pt = data;
            REG_END_POINT:     end_pt = data;
            REG_START_TANGENT: start_tan = data;
            REG_END_TANGENT:   end_tan = data;
            REG_POINT_COUNT:   count_reg = data[CNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Last valid index after the count is clamped to 2..MAX_POINTS.
      function longint last_index();
         longint n;
         n = count_reg;
         if (n < 2) n = 2;
         if (n > HCC_MAX_POINTS) n = HCC_MAX_POINTS;
         return n - 1;
      endfunction

      function longint coord_at(logic [VEC_W-1:0] vec, int k);
         logic signed [HCC_COORD_WIDTH-1:0] c;
         c = vec[HCC_COORD_WIDTH*k +: HCC_COORD_WIDTH];
         return c;
      endfunction

      function curve_point_type eval_point(logic [IDX_W-1:0] idx);
         longint          last, i, u, u2, u3;
         longint          h0, h1, h2, h3, s, r;
         longint          res[3];
         curve_point_type p;
         last = last_index();
         i = idx;
         if (i > last) i = last;
         // u = i/(N-1) rounded half up, then its square and cube in Q1.16.
         u  = (i * UNIT_Q16 + last / 2) / last;
         u2 = (u * u + ROUND_HALF) >>> FRAC_W;
         u3 = (u2 * u + ROUND_HALF) >>> FRAC_W;
         h0 = 2 * u3 - 3 * u2 + UNIT_Q16;
         h1 = -2 * u3 + 3 * u2;
         h2 = u3 - 2 * u2 + u;
         h3 = u3 - u2;
         p.idx = idx;
         p.sat = 1'b0;
         for (int k = 0; k < 3; k++) begin
            s = h0 * coord_at(start_pt, k) + h1 * coord_at(end_pt, k)
              + h2 * coord_at(start_tan, k) + h3 * coord_at(end_tan, k);
            // Arithmetic shift gives the floor, so halves round up.
            r = (s + ROUND_HALF) >>> FRAC_W;
            if (r > COORD_MAX) begin
               r = COORD_MAX;
               p.sat = 1'b1;
            end
            if (r < COORD_MIN) begin
               r = COORD_MIN;
               p.sat = 1'b1;
            end
            res[k] = r;
         end
         p.x = HCC_COORD_WIDTH'(res[0]);
         p.y = HCC_COORD_WIDTH'(res[1]);
         p.z = HCC_COORD_WIDTH'(res[2]);
         return p;
      endfunction

      function void note_sample(logic [IDX_W-1:0] idx);
         expected_q.push_back(eval_point(idx));
      endfunction

      function void check_point(logic signed [HCC_COORD_WIDTH-1:0] x,
                                logic signed [HCC_COORD_WIDTH-1:0] y,
                                logic signed [HCC_COORD_WIDTH-1:0] z,
                                logic sat);
         curve_point_type e;
         points_checked++;
         if (sat === 1'b1) saturated_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result beat with nothing expected: x=%0d y=%0d z=%0d sat=%0b",
                        $realtime, x, y, z, sat);
            return;
         end
         e = expected_q.pop_front();
         if (x !== e.x || y !== e.y || z !== e.z || sat !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: index %0d: expected x=%0d y=%0d z=%0d sat=%0b,%s",
                        $realtime, e.idx, e.x, e.y, e.z, e.sat,
                        $sformatf(" got x=%0d y=%0d z=%0d sat=%0b", x, y, z, sat));
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [IDX_W-1:0]                  req_sample_index;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [HCC_COORD_WIDTH-1:0] rsp_pos_x;
   logic signed [HCC_COORD_WIDTH-1:0] rsp_pos_y;
   logic signed [HCC_COORD_WIDTH-1:0] rsp_pos_z;
   logic                              rsp_saturated;
   logic                              csr_write_en;
   logic [CSR_INDEX_W-1:0]            csr_index;
   logic [VEC_W-1:0]                  csr_wdata;

   curve_scoreboard sb = new;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int samples_sent = 0;
   int reg_writes = 0;
   int settings_used = 0;
   int errors;

   hermite_cubic_curve_point dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_saturated    (rsp_saturated),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit, far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("hermite_cubic_curve_point_test: done, errors");
      $finish;
   end

   // Observe every beat and register write at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_en) begin
            sb.write_reg(csr_index, csr_wdata);
            reg_writes++;
         end
         if (req_valid && req_ready) begin
            sb.note_sample(req_sample_index);
            samples_sent++;
         end
         if (rsp_valid && rsp_ready)
            sb.check_point(rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_saturated);
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offer one sample index and wait for its beat; valid stays up afterwards.
   task automatic send_sample(input logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample_index = idx;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [VEC_W-1:0] data);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Wait until every expected point has come back.
   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] cnt);
      logic [VEC_W-1:0] d;
      // Upper bits carry noise; only the low bits form the count.
      d = VEC_W'({$urandom, $urandom});
      d[CNT_W-1:0] = cnt;
      write_csr(REG_POINT_COUNT, d);
   endtask

   task automatic apply_setting(input logic [VEC_W-1:0] sp, input logic [VEC_W-1:0] ep,
                                input logic [VEC_W-1:0] st, input logic [VEC_W-1:0] et,
                                input logic [CNT_W-1:0] cnt);
      drain();
      write_csr(REG_START_POINT, sp);
      write_csr(REG_END_POINT, ep);
      write_csr(REG_START_TANGENT, st);
      write_csr(REG_END_TANGENT, et);
      write_count(cnt);
      settings_used++;
   endtask

   task automatic write_unused_reg();
      write_csr(CSR_INDEX_W'(REG_FIRST_UNUSED + $urandom_range(2)),
                VEC_W'({$urandom, $urandom}));
   endtask

   function automatic logic [VEC_W-1:0] rand_vec();
      logic [VEC_W-1:0] v;
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(5))
            0: v[HCC_COORD_WIDTH*k +: HCC_COORD_WIDTH] = 16'h7FFF;
            1: v[HCC_COORD_WIDTH*k +: HCC_COORD_WIDTH] = 16'h8000;
            2: v[HCC_COORD_WIDTH*k +: HCC_COORD_WIDTH] = 16'h0000;
            3: v[HCC_COORD_WIDTH*k +: HCC_COORD_WIDTH] = 16'(int'($urandom_range(511)) - 256);
            default: v[HCC_COORD_WIDTH*k +: HCC_COORD_WIDTH] = 16'($urandom);
         endcase
      end
      return v;
   endfunction

   function automatic logic [CNT_W-1:0] rand_count();
      case ($urandom_range(9))
         0: return CNT_W'($urandom_range(1));
         1: return CNT_W'(2);
         2: return CNT_W'(HCC_MAX_POINTS);
         3: return CNT_W'($urandom);
         4, 5, 6: return CNT_W'($urandom_range(64, 2));
         default: return CNT_W'($urandom_range(HCC_MAX_POINTS, 2));
      endcase
   endfunction

   // Mostly in-range indexes, with the ends and past-end values mixed in.
   function automatic logic [IDX_W-1:0] pick_index();
      longint last;
      last = sb.last_index();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return IDX_W'(last);
         3, 4: return IDX_W'($urandom);
         default: return IDX_W'($urandom_range(int'(last)));
      endcase
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_index = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      sb.clear();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: values after reset, with an index past the default end.
      settings_used = 1;
      send_sample(IDX_W'(0));
      send_sample(IDX_W'(40));
      send_sample(IDX_W'(63));
      send_sample(IDX_W'(1023));

      // Directed: extreme coordinates, short curve, both ends and past end.
      apply_setting({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, CNT_W'(5));
      send_sample(IDX_W'(0));
      send_sample(IDX_W'(1));
      send_sample(IDX_W'(2));
      send_sample(IDX_W'(4));
      send_sample(IDX_W'(1023));

      // Directed: count of zero acts as two points.
      apply_setting({16'h0001, 16'h7FFF, 16'h8000}, {16'h8000, 16'h0000, 16'h7FFF},
                    {3{16'h8000}}, {3{16'h7FFF}}, CNT_W'(0));
      send_sample(IDX_W'(0));
      send_sample(IDX_W'(1));
      send_sample(IDX_W'(700));

      // Directed: count of one, also two points.
      drain();
      write_count(CNT_W'(1));
      settings_used++;
      send_sample(IDX_W'(0));
      send_sample(IDX_W'(1));

      // Directed: count just above the maximum is clamped to it.
      drain();
      write_count(CNT_W'(HCC_MAX_POINTS + 1));
      settings_used++;
      send_sample(IDX_W'(0));
      send_sample(IDX_W'(512));
      send_sample(IDX_W'(1023));

      // Directed: largest count the register holds.
      drain();
      write_count('1);
      settings_used++;
      send_sample(IDX_W'(1000));

      // Directed: exact maximum count, and writes to unused indexes change nothing.
      drain();
      write_count(CNT_W'(HCC_MAX_POINTS));
      write_csr(REG_FIRST_UNUSED, '1);
      write_csr(CSR_INDEX_W'(REG_FIRST_UNUSED + 1), VEC_W'({$urandom, $urandom}));
      write_csr('1, VEC_W'({$urandom, $urandom}));
      settings_used++;
      send_sample(IDX_W'(1023));
      send_sample(IDX_W'(511));
      send_sample(IDX_W'(1));

      // Random phases, each with its own setting and idling mode.
      for (int ph = 0; ph < PHASES; ph++) begin
         apply_setting(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_count());
         if ($urandom_range(3) == 0) write_unused_reg();
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 59;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 59;
            end
            default: begin
               send_idle_pct = 13;
               stall_pct = 13;
            end
         endcase
         // The receiver holds off while the sender keeps going, filling the pipeline.
         if (ph == 4) hold_cycles = HOLD_OFF_CYCLES;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // The sender pauses once until the block has emptied.
            if (ph == 5 && n == ITEMS_PER_PHASE / 2) drain();
            send_sample(pick_index());
         end
      end

      // Let everything come back, then give stray beats a chance to show.
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      errors = sb.mismatches;
      if (sb.pending() != 0) begin
         $display("%0d expected curve points never came back", sb.pending());
         errors += sb.pending();
      end
      $display("Sent %0d sample beats over %0d register settings (%0d register writes).",
               samples_sent, settings_used, reg_writes);
      $display("Checked %0d curve points, %0d of them saturated; %0d mismatches.",
               sb.points_checked, sb.saturated_seen, sb.mismatches);
      if (errors == 0) begin
         $display("hermite_cubic_curve_point_test: done, clean");
      end else begin
         $display("hermite_cubic_curve_point_test: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/hcc_pkg.sv
design/hcc_divider.sv
design/hcc_basis.sv
design/hcc_blend.sv
design/hermite_cubic_curve_point.sv
sim/hermite_cubic_curve_point_test.sv
